### hdl/lsch_pkg.sv
`default_nettype none

package lsch_pkg;

   typedef enum logic [1:0] {
      MODE_LOAD     = 2'd0,
      MODE_IO       = 2'd1,
      MODE_MARK     = 2'd2,
      MODE_SCHEDULE = 2'd3
   } mode_type;

   typedef struct packed {
      logic load;
      logic inc_rd;
      logic inc_wr;
      logic mark;
      logic clear;
   } cell_ctl_type;

endpackage

`default_nettype wire

### hdl/lsch_cell.sv
`default_nettype none

module lsch_cell #(
   parameter int COUNT_WIDTH = 16,
   parameter int PID_WIDTH   = 16,
   parameter int IDX_W       = 4,
   parameter int INDEX       = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire lsch_pkg::cell_ctl_type ctl,
   input  wire  [PID_WIDTH-1:0]     wr_pid,
   input  wire                      in_vld,
   input  wire  [COUNT_WIDTH:0]     in_key,
   input  wire  [PID_WIDTH-1:0]     in_pid,
   input  wire  [IDX_W-1:0]         in_idx,
   output logic                     out_vld,
   output logic [COUNT_WIDTH:0]     out_key,
   output logic [PID_WIDTH-1:0]     out_pid,
   output logic [IDX_W-1:0]         out_idx,
   output logic [PID_WIDTH-1:0]     own_pid,
   output logic [COUNT_WIDTH:0]     own_key
);

   logic [PID_WIDTH-1:0]   pid_ff;
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic [COUNT_WIDTH-1:0] wr_ff;
   logic                   ready_ff;
   logic                   vld_ff;
   logic [COUNT_WIDTH:0]   key_ff;
   logic [PID_WIDTH-1:0]   best_pid_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [COUNT_WIDTH:0]   key;
   logic                   own_wins;

   assign key = {1'b0, rd_ff} + {1'b0, wr_ff};
   assign own_wins = ready_ff &&
                     (!in_vld || key < in_key || (key == in_key && pid_ff < in_pid));

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pid_ff <= wr_pid;
      end
      best_pid_ff <= own_wins ? pid_ff : in_pid;
      key_ff      <= own_wins ? key : in_key;
      idx_ff      <= own_wins ? IDX_W'(INDEX) : in_idx;
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         ready_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         vld_ff <= own_wins || in_vld;
         if (ctl.load) begin
            rd_ff <= '0;
            wr_ff <= '0;
         end else begin
            if (ctl.inc_rd && rd_ff != '1) begin
               rd_ff <= rd_ff + COUNT_WIDTH'(1);
            end
            if (ctl.inc_wr && wr_ff != '1) begin
               wr_ff <= wr_ff + COUNT_WIDTH'(1);
            end
         end
         priority if (ctl.clear) begin
            ready_ff <= 1'b0;
         end else if (ctl.load || ctl.mark) begin
            ready_ff <= 1'b1;
         end
      end
   end

   assign out_vld = vld_ff;
   assign out_key = key_ff;
   assign out_pid = best_pid_ff;
   assign out_idx = idx_ff;
   assign own_pid = pid_ff;
   assign own_key = key;

endmodule

`default_nettype wire

### hdl/least_io_process_scheduler_top.sv
`default_nettype none
// Load, I/O event and mark ready: the word passes S_APPLY, then S_OUT, then the result strobe.
// Schedule: the word passes S_SCAN, S_SCHED and S_OUT; the result is set by the
// compare chain, which moves the best candidate one slot cell per cycle.
// One word at a time; busy is high from accept until the result strobe.
// Synchronous reset clears counters, ready marks and the running slot; pids are not reset.
// The receiver cannot stall: each result shows on rsp_strobe for one cycle.

module least_io_process_scheduler_top #(
   parameter int SLOTS       = 16,
   parameter int COUNT_WIDTH = 16,
   parameter int PID_WIDTH   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_mode,
   input  wire  [3:0]  req_slot,
   input  wire  [15:0] req_pid,
   input  wire         req_was_read,
   input  wire         req_keep_running,
   output logic        rsp_strobe,
   output logic        rsp_idle,
   output logic [3:0]  rsp_running_slot,
   output logic [15:0] rsp_running_pid,
   output logic [16:0] rsp_running_io
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 2);
   localparam int KEY_W = COUNT_WIDTH + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPLY,
      S_SCAN,
      S_SCHED,
      S_OUT
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       cnt_ff;
   lsch_pkg::mode_type     mode_ff;
   logic [3:0]             slot_ff;
   logic [PID_WIDTH-1:0]   pid_ff;
   logic                   rd_ff;
   logic                   keep_ff;
   logic                   run_ff;
   logic [IDX_W-1:0]       cur_ff;
   logic                   strobe_ff;
   logic                   idle_ff;
   logic [3:0]             rslot_ff;
   logic [15:0]            rpid_ff;
   logic [16:0]            rio_ff;

   lsch_pkg::cell_ctl_type ctl [SLOTS];
   logic                   ch_vld [SLOTS+1];
   logic [KEY_W-1:0]       ch_key [SLOTS+1];
   logic [PID_WIDTH-1:0]   ch_pid [SLOTS+1];
   logic [IDX_W-1:0]       ch_idx [SLOTS+1];
   logic [PID_WIDTH-1:0]   cell_pid [SLOTS];
   logic [KEY_W-1:0]       cell_key [SLOTS];

   assign ch_vld[0] = 1'b0;
   assign ch_key[0] = '0;
   assign ch_pid[0] = '0;
   assign ch_idx[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic hit;
      logic apply;
      assign hit   = (32'(slot_ff) == i);
      assign apply = (state_ff == S_APPLY) && hit;

      always_comb begin
         ctl[i].load   = apply && (mode_ff == lsch_pkg::MODE_LOAD);
         ctl[i].inc_rd = apply && (mode_ff == lsch_pkg::MODE_IO) && rd_ff;
         ctl[i].inc_wr = apply && (mode_ff == lsch_pkg::MODE_IO) && !rd_ff;
         ctl[i].mark   = (apply && (mode_ff == lsch_pkg::MODE_MARK)) ||
                         ((state_ff == S_SCHED) && run_ff && keep_ff && 32'(cur_ff) == i);
         ctl[i].clear  = (state_ff == S_SCHED) && ch_vld[SLOTS] &&
                         32'(ch_idx[SLOTS]) == i;
      end

      lsch_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .PID_WIDTH   (PID_WIDTH),
         .IDX_W       (IDX_W),
         .INDEX       (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl[i]),
         .wr_pid  (pid_ff),
         .in_vld  (ch_vld[i]),
         .in_key  (ch_key[i]),
         .in_pid  (ch_pid[i]),
         .in_idx  (ch_idx[i]),
         .out_vld (ch_vld[i+1]),
         .out_key (ch_key[i+1]),
         .out_pid (ch_pid[i+1]),
         .out_idx (ch_idx[i+1]),
         .own_pid (cell_pid[i]),
         .own_key (cell_key[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         run_ff    <= 1'b0;
         cur_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff <= lsch_pkg::mode_type'(req_mode);
                  slot_ff <= req_slot;
                  pid_ff  <= PID_WIDTH'(req_pid);
                  rd_ff   <= req_was_read;
                  keep_ff <= req_keep_running;
                  cnt_ff  <= '0;
                  state_ff <= (lsch_pkg::mode_type'(req_mode) == lsch_pkg::MODE_SCHEDULE) ?
                              S_SCAN : S_APPLY;
               end
            end
            S_APPLY: begin
               state_ff <= S_OUT;
            end
            S_SCAN: begin
               if (cnt_ff == CNT_W'(SLOTS)) begin
                  state_ff <= S_SCHED;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_SCHED: begin
               run_ff <= ch_vld[SLOTS];
               if (ch_vld[SLOTS]) begin
                  cur_ff <= ch_idx[SLOTS];
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               strobe_ff <= 1'b1;
               idle_ff   <= !run_ff;
               rslot_ff  <= run_ff ? 4'(cur_ff) : 4'd0;
               rpid_ff   <= run_ff ? 16'(cell_pid[cur_ff]) : 16'd0;
               rio_ff    <= run_ff ? 17'(cell_key[cur_ff]) : 17'd0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_idle         = idle_ff;
   assign rsp_running_slot = rslot_ff;
   assign rsp_running_pid  = rpid_ff;
   assign rsp_running_io   = rio_ff;

endmodule

`default_nettype wire

### hdl/lsch_checker.sv
`default_nettype none

module lsch_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_strobe,
   input wire        rsp_idle,
   input wire [3:0]  rsp_running_slot,
   input wire [15:0] rsp_running_pid,
   input wire [16:0] rsp_running_io
);

   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe longer than one cycle");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_idle) |->
      (rsp_running_slot == 4'd0 && rsp_running_pid == 16'd0 && rsp_running_io == 17'd0))
      else $error("idle result with nonzero fields");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe)) else $error("not quiet after reset");

endmodule

bind least_io_process_scheduler_top lsch_checker u_lsch_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_idle         (rsp_idle),
   .rsp_running_slot (rsp_running_slot),
   .rsp_running_pid  (rsp_running_pid),
   .rsp_running_io   (rsp_running_io)
);

`default_nettype wire
